/* rtl/core/bresenham_line_rect_rasterizer_assert.svh */
// assertion macros used by the rasteriser core
`ifndef BRESENHAM_LINE_RECT_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RECT_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define BLR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasteriser check failed");

// next-cycle implication
`define BLR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasteriser check failed");

`endif

/* rtl/core/blr_pkg.sv */
// ---------------------------------------------------------------------------
// blr_pkg
// shared codes, defaults and types for the line and rectangle rasteriser
// ---------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_LINE = 2'd0,
        OP_STEP = 2'd1,
        OP_RECT = 2'd2
    } blr_op_t;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    typedef struct packed {
        logic line_end;
        logic shape_end;
    } blr_flags_t;

endpackage

`default_nettype wire

/* rtl/core/blr_setup.sv */
// ---------------------------------------------------------------------------
// blr_setup
// line setup: directions, absolute distances and initial error
// ---------------------------------------------------------------------------
`default_nettype none

module blr_setup
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic [COORD_BITS-1:0]        xs,
    input  wire logic [COORD_BITS-1:0]        ys,
    input  wire logic [COORD_BITS-1:0]        xe,
    input  wire logic [COORD_BITS-1:0]        ye,
    output logic      [COORD_BITS-1:0]        dist_x,
    output logic      [COORD_BITS-1:0]        dist_y,
    output logic                              neg_x,
    output logic                              neg_y,
    output logic signed [COORD_BITS+1:0]      err
);

    logic lt_x;
    logic lt_y;

    always_comb
    begin
        lt_x   = xs < xe;
        lt_y   = ys < ye;
        neg_x  = !lt_x;
        neg_y  = !lt_y;
        dist_x = lt_x ? (xe - xs) : (xs - xe);
        dist_y = lt_y ? (ye - ys) : (ys - ye);
        // half of the major distance, rounded toward zero
        if (dist_x > dist_y)
        begin
            err = $signed({3'b000, dist_x[COORD_BITS-1:1]});
        end
        else
        begin
            err = -$signed({3'b000, dist_y[COORD_BITS-1:1]});
        end
    end

endmodule

`default_nettype wire

/* rtl/core/blr_core.sv */
// ---------------------------------------------------------------------------
// blr_core
// shape state and single-pass pixel step, one item per cycle while take is high
// ---------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rect_rasterizer_assert.svh"

module blr_core
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    take,
    input  wire logic [1:0]              op,
    input  wire logic [COORD_BITS-1:0]   x_a,
    input  wire logic [COORD_BITS-1:0]   y_a,
    input  wire logic [COORD_BITS-1:0]   x_b,
    input  wire logic [COORD_BITS-1:0]   y_b,
    output logic                         res_load,
    output logic [COORD_BITS-1:0]        res_x,
    output logic [COORD_BITS-1:0]        res_y,
    output blr_flags_t                   res_flags
);

    localparam int W = COORD_BITS;
    localparam logic [W-1:0] ONE = W'(1);

    logic [W-1:0]        cur_x_reg, cur_x_next;
    logic [W-1:0]        cur_y_reg, cur_y_next;
    logic [W-1:0]        tgt_x_reg, tgt_x_next;
    logic [W-1:0]        tgt_y_reg, tgt_y_next;
    logic [W-1:0]        dist_x_reg, dist_x_next;
    logic [W-1:0]        dist_y_reg, dist_y_next;
    logic                neg_x_reg, neg_x_next;
    logic                neg_y_reg, neg_y_next;
    logic signed [W+1:0] err_reg, err_next;
    logic                busy_reg, busy_next;
    logic                rect_reg, rect_next;
    logic [1:0]          edge_reg, edge_next;
    logic [W-1:0]        left_reg, left_next;
    logic [W-1:0]        top_reg, top_next;
    logic [W-1:0]        right_reg, right_next;
    logic [W-1:0]        bottom_reg, bottom_next;

    logic [W-1:0]        ld_xs, ld_ys, ld_xe, ld_ye;
    logic [W-1:0]        ld_dist_x, ld_dist_y;
    logic                ld_neg_x, ld_neg_y;
    logic signed [W+1:0] ld_err;
    logic [1:0]          edge_inc;
    logic                at_target;
    logic signed [W+1:0] dxs, dys;
    logic                load_line;
    logic                emit;
    logic                last_px;

    assign edge_inc  = edge_reg + 2'd1;
    assign at_target = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign dxs       = $signed({2'b00, dist_x_reg});
    assign dys       = $signed({2'b00, dist_y_reg});

    // endpoint selection for the setup unit
    always_comb
    begin
        ld_xs = x_a;
        ld_ys = y_a;
        ld_xe = x_b;
        ld_ye = y_b;
        if (blr_op_t'(op) == OP_RECT)
        begin
            ld_xe = x_a + x_b;
            ld_ye = y_a;
        end
        else if (blr_op_t'(op) == OP_STEP)
        begin
            case (edge_inc)
                EDGE_LEFT:
                begin
                    ld_xs = left_reg;
                    ld_ys = top_reg;
                    ld_xe = left_reg;
                    ld_ye = bottom_reg;
                end
                EDGE_BOTTOM:
                begin
                    ld_xs = left_reg;
                    ld_ys = bottom_reg;
                    ld_xe = right_reg;
                    ld_ye = bottom_reg;
                end
                EDGE_RIGHT:
                begin
                    ld_xs = right_reg;
                    ld_ys = top_reg;
                    ld_xe = right_reg;
                    ld_ye = bottom_reg;
                end
                default:
                begin
                    ld_xs = left_reg;
                    ld_ys = top_reg;
                    ld_xe = right_reg;
                    ld_ye = top_reg;
                end
            endcase
        end
    end

    blr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .xs     (ld_xs),
        .ys     (ld_ys),
        .xe     (ld_xe),
        .ye     (ld_ye),
        .dist_x (ld_dist_x),
        .dist_y (ld_dist_y),
        .neg_x  (ld_neg_x),
        .neg_y  (ld_neg_y),
        .err    (ld_err)
    );

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dist_x_next = dist_x_reg;
        dist_y_next = dist_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        busy_next   = busy_reg;
        rect_next   = rect_reg;
        edge_next   = edge_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        load_line   = 1'b0;
        emit        = 1'b0;

        if (take)
        begin
            case (blr_op_t'(op))
                OP_LINE:
                begin
                    rect_next = 1'b0;
                    edge_next = EDGE_TOP;
                    load_line = 1'b1;
                    emit      = 1'b1;
                end
                OP_RECT:
                begin
                    rect_next   = 1'b1;
                    edge_next   = EDGE_TOP;
                    left_next   = x_a;
                    top_next    = y_a;
                    right_next  = x_a + x_b;
                    bottom_next = y_a + y_b;
                    load_line   = 1'b1;
                    emit        = 1'b1;
                end
                OP_STEP:
                begin
                    if (busy_reg)
                    begin
                        emit = 1'b1;
                        if (at_target)
                        begin
                            // edge done, move on to the next one
                            edge_next = edge_inc;
                            load_line = 1'b1;
                        end
                        else
                        begin
                            if (err_reg > -dxs)
                            begin
                                err_next   = err_next - dys;
                                cur_x_next = neg_x_reg ? cur_x_reg - ONE : cur_x_reg + ONE;
                            end
                            if (err_reg < dys)
                            begin
                                err_next   = err_next + dxs;
                                cur_y_next = neg_y_reg ? cur_y_reg - ONE : cur_y_reg + ONE;
                            end
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (load_line)
        begin
            cur_x_next  = ld_xs;
            cur_y_next  = ld_ys;
            tgt_x_next  = ld_xe;
            tgt_y_next  = ld_ye;
            dist_x_next = ld_dist_x;
            dist_y_next = ld_dist_y;
            neg_x_next  = ld_neg_x;
            neg_y_next  = ld_neg_y;
            err_next    = ld_err;
        end

        last_px = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        res_flags.line_end  = last_px;
        res_flags.shape_end = last_px && (!rect_next || (edge_next == EDGE_RIGHT));

        if (emit)
        begin
            busy_next = !res_flags.shape_end;
        end
    end

    assign res_load = emit;
    assign res_x    = cur_x_next;
    assign res_y    = cur_y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dist_x_reg <= '0;
            dist_y_reg <= '0;
            neg_x_reg  <= 1'b0;
            neg_y_reg  <= 1'b0;
            err_reg    <= '0;
            busy_reg   <= 1'b0;
            rect_reg   <= 1'b0;
            edge_reg   <= EDGE_TOP;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dist_x_reg <= dist_x_next;
            dist_y_reg <= dist_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            err_reg    <= err_next;
            busy_reg   <= busy_next;
            rect_reg   <= rect_next;
            edge_reg   <= edge_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

    // a finished shape leaves the block idle
    `BLR_ASSERT_NXT(a_end_goes_idle, clk, rst_n, res_load && res_flags.shape_end, !busy_reg)
    // only a rectangle can sit at the end of an edge while busy, and never on the last edge
    `BLR_ASSERT_IMP(a_edge_wait_rect, clk, rst_n, busy_reg && at_target,
                    rect_reg && (edge_reg != EDGE_RIGHT))
    // edges other than the first belong to rectangles
    `BLR_ASSERT_IMP(a_edge_only_rect, clk, rst_n, edge_reg != EDGE_TOP, rect_reg)
    // shape end is always a line end
    `BLR_ASSERT_IMP(a_shape_is_line_end, clk, rst_n, res_load && res_flags.shape_end,
                    res_flags.line_end)

endmodule

`default_nettype wire

/* rtl/core/blr_out.sv */
// ---------------------------------------------------------------------------
// blr_out
// result register between the pixel step and the output channel
// ---------------------------------------------------------------------------
`default_nettype none

module blr_out
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic [COORD_BITS-1:0]   res_x,
    input  wire logic [COORD_BITS-1:0]   res_y,
    input  wire blr_flags_t              res_flags,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic                         free,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic                         line_end,
    output logic                         shape_end
);

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    blr_flags_t            flags_reg;

    // register can take a new pixel when empty or being drained
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            x_reg     <= res_x;
            y_reg     <= res_y;
            flags_reg <= res_flags;
        end
    end

    assign out_valid = valid_reg;
    assign pixel_x   = x_reg;
    assign pixel_y   = y_reg;
    assign line_end  = flags_reg.line_end;
    assign shape_end = flags_reg.shape_end;

endmodule

`default_nettype wire

/* rtl/core/bresenham_line_rect_rasterizer.sv */
// ---------------------------------------------------------------------------
// bresenham_line_rect_rasterizer
// integer line and rectangle outline pixel generator
//
//   channel  handshake              payload
//   in       in_valid / in_ready    op, x_a, y_a, x_b, y_b
//   out      out_valid / out_ready  pixel_x, pixel_y, line_end, shape_end
//
// one item per cycle while in_ready is high; a pixel appears in the cycle after its item is taken
// the step and line setup sit between the input and the result register
// in_ready is low only while a pixel waits in the result register unread
// items that make no pixel are taken and leave nothing behind
// reset clears all shape state to idle
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rect_rasterizer
    import blr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              op,
    input  wire logic [COORD_BITS-1:0]   x_a,
    input  wire logic [COORD_BITS-1:0]   y_a,
    input  wire logic [COORD_BITS-1:0]   x_b,
    input  wire logic [COORD_BITS-1:0]   y_b,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic                         line_end,
    output logic                         shape_end
);

    logic                  take;
    logic                  free;
    logic                  res_load;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    blr_flags_t            res_flags;

    assign in_ready = free;
    assign take     = in_valid && free;

    blr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .op        (op),
        .x_a       (x_a),
        .y_a       (y_a),
        .x_b       (x_b),
        .y_b       (y_b),
        .res_load  (res_load),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_flags (res_flags)
    );

    blr_out #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_flags (res_flags),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (free),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .line_end  (line_end),
        .shape_end (shape_end)
    );

endmodule

`default_nettype wire

/* tb/tb_bresenham_line_rect_rasterizer.sv */
// ---------------------------------------------------------------------------
// tb_bresenham_line_rect_rasterizer
// self-checking bench for the line and rectangle pixel generator
//
// a short stimulus plan covers reset, idle steps, the unused op code, the
// coordinate extremes, restarts, corner wrap and a zero-size rectangle.
// random line and rectangle sequences follow, mostly small and sometimes cut
// short by a new start. every accepted item is run through a local pixel
// predictor and each output pixel is compared field by field with the oldest
// expected pixel. both channels idle at random in two of three phases
// ---------------------------------------------------------------------------
module tb_bresenham_line_rect_rasterizer
    import blr_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PIXEL_TARGET = 550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_LEN = 23;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       line_end;
        logic       shape_end;
    } pixel_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_PIXEL,
        KNOWN_PIXEL
    } check_t;

    typedef struct packed {
        logic [1:0] opc;
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        check_t     chk;
        pixel_t     want;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       line_end;
    logic       shape_end;

    // predictor state
    logic [7:0]        pen_x, pen_y, goal_x, goal_y, span_x, span_y;
    logic              x_down, y_down, drawing, in_rect;
    logic signed [9:0] err_acc;
    logic [1:0]        side;
    logic [7:0]        rc_left, rc_top, rc_right, rc_bottom;

    pixel_t pending_pixels[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     pixels_made = 0;
    int     pixels_seen = 0;
    int     lines_started = 0;
    int     rects_started = 0;
    int     gap_pct = 25;
    int     stall_pct = 60;
    int     cycle_count = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   NO_PIXEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, NO_PIXEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_LINE,   8'd0,   8'd0,   8'd0,   8'd0,   KNOWN_PIXEL, '{8'd0,   8'd0,   1'b1, 1'b1}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   NO_PIXEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_LINE,   8'd255, 8'd255, 8'd0,   8'd0,   KNOWN_PIXEL, '{8'd255, 8'd255, 1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_STEP,   8'd255, 8'd255, 8'd255, 8'd255, BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_LINE,   8'd0,   8'd255, 8'd255, 8'd0,   KNOWN_PIXEL, '{8'd0,   8'd255, 1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_UNUSED, 8'd0,   8'd0,   8'd0,   8'd0,   NO_PIXEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_LINE,   8'd10,  8'd20,  8'd13,  8'd30,  KNOWN_PIXEL, '{8'd10,  8'd20,  1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_RECT,   8'd250, 8'd250, 8'd10,  8'd10,  KNOWN_PIXEL, '{8'd250, 8'd250, 1'b0, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   BY_MODEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_RECT,   8'd0,   8'd0,   8'd255, 8'd255, KNOWN_PIXEL, '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_RECT,   8'd100, 8'd100, 8'd0,   8'd0,   KNOWN_PIXEL, '{8'd100, 8'd100, 1'b1, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   KNOWN_PIXEL, '{8'd100, 8'd100, 1'b1, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   KNOWN_PIXEL, '{8'd100, 8'd100, 1'b1, 1'b0}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   KNOWN_PIXEL, '{8'd100, 8'd100, 1'b1, 1'b1}},
        '{OP_STEP,   8'd0,   8'd0,   8'd0,   8'd0,   NO_PIXEL,    '{8'd0,   8'd0,   1'b0, 1'b0}},
        '{OP_RECT,   8'd7,   8'd9,   8'd1,   8'd2,   KNOWN_PIXEL, '{8'd7,   8'd9,   1'b0, 1'b0}}
    };

    bresenham_line_rect_rasterizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .x_a       (x_a),
        .y_a       (y_a),
        .x_b       (x_b),
        .y_b       (y_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .line_end  (line_end),
        .shape_end (shape_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void aim_segment(input logic [7:0] xs, input logic [7:0] ys,
                                        input logic [7:0] xe, input logic [7:0] ye);
        pen_x  = xs;
        pen_y  = ys;
        goal_x = xe;
        goal_y = ye;
        x_down = !(xs < xe);
        y_down = !(ys < ye);
        span_x = (xs < xe) ? xe - xs : xs - xe;
        span_y = (ys < ye) ? ye - ys : ys - ye;
        if (span_x > span_y)
            err_acc = $signed({2'b00, span_x >> 1});
        else
            err_acc = -$signed({2'b00, span_y >> 1});
    endfunction

    function automatic void load_side(input logic [1:0] s);
        case (s)
            EDGE_TOP:    aim_segment(rc_left, rc_top, rc_right, rc_top);
            EDGE_LEFT:   aim_segment(rc_left, rc_top, rc_left, rc_bottom);
            EDGE_BOTTOM: aim_segment(rc_left, rc_bottom, rc_right, rc_bottom);
            default:     aim_segment(rc_right, rc_top, rc_right, rc_bottom);
        endcase
    endfunction

    function automatic pixel_t light_pixel();
        pixel_t p;
        p.x = pen_x;
        p.y = pen_y;
        p.line_end = (pen_x == goal_x) && (pen_y == goal_y);
        p.shape_end = p.line_end && (!in_rect || side == EDGE_RIGHT);
        if (p.shape_end)
            drawing = 1'b0;
        return p;
    endfunction

    // advances the predictor by one item; returns 1 when a pixel comes out
    function automatic bit rasterise(input logic [1:0] opc, input logic [7:0] xa,
                                     input logic [7:0] ya, input logic [7:0] xb,
                                     input logic [7:0] yb, output pixel_t px);
        logic signed [9:0] e;
        px = '0;
        case (opc)
            OP_LINE:
            begin
                in_rect = 1'b0;
                side = EDGE_TOP;
                drawing = 1'b1;
                aim_segment(xa, ya, xb, yb);
                px = light_pixel();
                return 1'b1;
            end
            OP_RECT:
            begin
                in_rect = 1'b1;
                side = EDGE_TOP;
                drawing = 1'b1;
                rc_left = xa;
                rc_top = ya;
                rc_right = xa + xb;
                rc_bottom = ya + yb;
                load_side(EDGE_TOP);
                px = light_pixel();
                return 1'b1;
            end
            OP_STEP:
            begin
                if (!drawing)
                    return 1'b0;
                if (pen_x == goal_x && pen_y == goal_y)
                begin
                    // edge done, move on to the next one
                    side = side + 2'd1;
                    load_side(side);
                end
                else
                begin
                    e = err_acc;
                    if (e > -$signed({2'b00, span_x}))
                    begin
                        err_acc = err_acc - $signed({2'b00, span_y});
                        pen_x = x_down ? pen_x - 8'd1 : pen_x + 8'd1;
                    end
                    if (e < $signed({2'b00, span_y}))
                    begin
                        err_acc = err_acc + $signed({2'b00, span_x});
                        pen_y = y_down ? pen_y - 8'd1 : pen_y + 8'd1;
                    end
                end
                px = light_pixel();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    task automatic send_item(input logic [1:0] opc, input logic [7:0] xa, input logic [7:0] ya,
                             input logic [7:0] xb, input logic [7:0] yb,
                             input check_t chk, input pixel_t want);
        pixel_t px;
        bit     made;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        op  <= opc;
        x_a <= xa;
        y_a <= ya;
        x_b <= xb;
        y_b <= yb;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        made = rasterise(opc, xa, ya, xb, yb, px);
        if (made)
            pixels_made++;
        if (opc == OP_LINE)
            lines_started++;
        if (opc == OP_RECT)
            rects_started++;
        case (chk)
            KNOWN_PIXEL: pending_pixels.push_back(want);
            BY_MODEL:    if (made) pending_pixels.push_back(px);
            default:     ;
        endcase
        // sender idles 25 then 60, receiver 60 then 25, then neither
        if (pixels_made < PIXEL_TARGET / 3)
        begin
            gap_pct = 25;
            stall_pct = 60;
        end
        else if (pixels_made < 2 * PIXEL_TARGET / 3)
        begin
            gap_pct = 60;
            stall_pct = 25;
        end
        else
        begin
            gap_pct = 0;
            stall_pct = 0;
        end
    endtask

    function automatic logic [7:0] nearby(input logic [7:0] a, input int d);
        if (($urandom_range(1) == 1 && a >= d) || a + d > 255)
            return 8'(a - d);
        return 8'(a + d);
    endfunction

    task automatic draw_random();
        logic [7:0] xa, ya, xb, yb;
        bit         big;
        int         pick;
        pick = $urandom_range(99);
        big  = ($urandom_range(9) == 0);
        xa   = 8'($urandom_range(255));
        ya   = 8'($urandom_range(255));
        if (pick < 6)
        begin
            // noise: unused op or a step that may find the block idle
            send_item(($urandom_range(1) == 1) ? OP_UNUSED : OP_STEP, xa, ya,
                      8'($urandom_range(255)), 8'($urandom_range(255)), BY_MODEL, '0);
            return;
        end
        if (pick < 50)
        begin
            xb = big ? 8'($urandom_range(255)) : nearby(xa, $urandom_range(12));
            yb = big ? 8'($urandom_range(255)) : nearby(ya, $urandom_range(12));
            send_item(OP_LINE, xa, ya, xb, yb, BY_MODEL, '0);
        end
        else
        begin
            xb = big ? 8'($urandom_range(255)) : 8'($urandom_range(8));
            yb = big ? 8'($urandom_range(255)) : 8'($urandom_range(8));
            send_item(OP_RECT, xa, ya, xb, yb, BY_MODEL, '0);
        end
        while (drawing && pixels_made < PIXEL_TARGET)
        begin
            if ($urandom_range(99) < 3)
                return;
            if ($urandom_range(99) < 2)
                send_item(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)), BY_MODEL, '0);
            send_item(OP_STEP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), BY_MODEL, '0);
        end
        if ($urandom_range(9) == 0)
            send_item(OP_STEP, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), BY_MODEL, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen++;
            if (pending_pixels.size() == 0)
                report("unexpected pixel x", int'(pixel_x), 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.x)
                    report("pixel_x", int'(pixel_x), int'(want.x));
                if (pixel_y !== want.y)
                    report("pixel_y", int'(pixel_y), int'(want.y));
                if (line_end !== want.line_end)
                    report("line_end", int'(line_end), int'(want.line_end));
                if (shape_end !== want.shape_end)
                    report("shape_end", int'(shape_end), int'(want.shape_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        in_valid  <= 1'b0;
        out_ready <= 1'b0;
        op        <= OP_STEP;
        x_a       <= '0;
        y_a       <= '0;
        x_b       <= '0;
        y_b       <= '0;
        rst_n     <= 1'b0;
        drawing = 1'b0;
        in_rect = 1'b0;
        side = EDGE_TOP;
        aim_segment(8'd0, 8'd0, 8'd0, 8'd0);
        rc_left = '0;
        rc_top = '0;
        rc_right = '0;
        rc_bottom = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
            send_item(plan[i].opc, plan[i].xa, plan[i].ya, plan[i].xb, plan[i].yb,
                      plan[i].chk, plan[i].want);

        while (pixels_made < PIXEL_TARGET)
            draw_random();

        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d items, %0d lines and %0d rectangles started",
                 items_sent, lines_started, rects_started);
        $display("%0d pixels predicted, %0d pixels taken from the block",
                 pixels_made, pixels_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* bresenham_line_rect_rasterizer.f */
+incdir+rtl/core
rtl/core/blr_pkg.sv
rtl/core/blr_setup.sv
rtl/core/blr_core.sv
rtl/core/blr_out.sv
rtl/core/bresenham_line_rect_rasterizer.sv
tb/tb_bresenham_line_rect_rasterizer.sv
